// File: rtl/pir_pkg.sv
// Shared types, constants and saturating helpers for the photometric interaction row.
// Used by pir_mul, pir_recip, photometric_interaction_row_core and the bench tb.
package pir_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VW = 48;
    localparam int IW = 32;

    typedef logic signed [VW-1:0] val_t;
    typedef logic signed [IW-1:0] in_t;
    typedef logic [1:0] mode_t;

    localparam mode_t MODE_PERSP     = 2'd0;
    localparam mode_t MODE_PAR       = 2'd1;
    localparam mode_t MODE_PAR_DEPTH = 2'd2;

    localparam val_t VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    function automatic val_t sat49(input logic [VW:0] s);
        val_t r;
        if (s[VW] != s[VW-1])
        begin
            r = s[VW] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            r = s[VW-1:0];
        end
        return r;
    endfunction

    function automatic val_t sat_add(input val_t a, input val_t b);
        return sat49({a[VW-1], a} + {b[VW-1], b});
    endfunction

    function automatic val_t sat_sub(input val_t a, input val_t b);
        return sat49({a[VW-1], a} - {b[VW-1], b});
    endfunction

    function automatic val_t sat_neg(input val_t a);
        return sat49({(VW+1){1'b0}} - {a[VW-1], a});
    endfunction

    function automatic val_t sext(input in_t a);
        return {{(VW-IW){a[IW-1]}}, a};
    endfunction

    function automatic bit is_parallel(input mode_t m);
        return (m == MODE_PAR) || (m == MODE_PAR_DEPTH);
    endfunction

    // numerator width of the reciprocal divider
    function automatic int div_width(input int f);
        return (2 * f + 2 > IW) ? 2 * f + 2 : IW;
    endfunction

endpackage

// File: rtl/photometric_interaction_row_core.sv
// Top level of the photometric interaction row pipeline.
// Depends on pir_pkg, pir_mul and pir_recip.
//
//  channel | handshake           | word
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid / in_stall | grad_x..grad_yy, norm_x, norm_y, depth, last_pixel
//  out     | out_valid/out_stall | row_vx..row_wz, gradient_depth_term, depth_zero,
//          |                     | end_of_set
//  cfg     | cfg_valid/cfg_ready | cfg_data = projection_mode
//
// One word per cycle sustained while the output is not stalled. The pipeline depth is set
// by the bit-per-stage reciprocal followed by one multiplier.
// Reset clears the valid bits, the output valid and the mode register.
// A stalled output freezes the whole pipeline; in_stall is high only then.
module photometric_interaction_row_core #(
    parameter int FRAC_BITS = pir_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   grad_x,
    input  logic signed [31:0]   grad_y,
    input  logic signed [31:0]   norm_x,
    input  logic signed [31:0]   norm_y,
    input  logic signed [31:0]   depth,
    input  logic signed [31:0]   grad_xx,
    input  logic signed [31:0]   grad_xy,
    input  logic signed [31:0]   grad_yx,
    input  logic signed [31:0]   grad_yy,
    input  logic                 last_pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [47:0]   row_vx,
    output logic signed [47:0]   row_vy,
    output logic signed [47:0]   row_vz,
    output logic signed [47:0]   row_wx,
    output logic signed [47:0]   row_wy,
    output logic signed [47:0]   row_wz,
    output logic signed [47:0]   gradient_depth_term,
    output logic                 depth_zero,
    output logic                 end_of_set,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data
);
    localparam int NW = pir_pkg::div_width(FRAC_BITS);
    localparam int D  = NW + 2;      // reciprocal ready
    localparam int LM = 4;           // multiplier latency
    localparam int L1 = D + LM;      // line1 length
    localparam int L2 = D - 1;       // line2 length
    localparam int WXI = 4;          // line2 index where wx/wy join
    localparam pir_pkg::val_t ONE = pir_pkg::val_t'(48'd1 << FRAC_BITS);

    localparam int PA_IYX = 0;
    localparam int PA_IXY = 1;
    localparam int PA_IYZ = 2;
    localparam int PA_IXZ = 3;
    localparam int PA_XXI = 4;
    localparam int PA_YXI = 5;
    localparam int PA_XYI = 6;
    localparam int PA_YYI = 7;
    localparam int PA_XY  = 8;
    localparam int PA_XIX = 9;
    localparam int PA_YIY = 10;
    localparam int PA_YY  = 11;
    localparam int PA_XX  = 12;
    localparam int NPA    = 13;

    typedef struct packed {
        pir_pkg::in_t ix;
        pir_pkg::in_t iy;
        logic         zero;
        logic         last;
    } line1_t;

    typedef struct packed {
        pir_pkg::val_t s;
        pir_pkg::val_t wxp;
        pir_pkg::val_t wyp;
        pir_pkg::val_t wz;
        pir_pkg::val_t gdt;
        pir_pkg::val_t wx;
        pir_pkg::val_t wy;
    } line2_t;

    typedef struct packed {
        pir_pkg::val_t s;
        pir_pkg::val_t wxp;
        pir_pkg::val_t wyp;
        pir_pkg::val_t wz;
        pir_pkg::val_t ga;
        pir_pkg::val_t gb;
        pir_pkg::val_t oyy;
        pir_pkg::val_t oxx;
        pir_pkg::val_t xy;
    } st5_t;

    logic          en;
    logic          vld_reg [0:L1-1];
    line1_t        line1_reg [0:L1-1];
    line2_t        line2_reg [0:L2-1];
    st5_t          st5_reg;
    pir_pkg::mode_t mode_reg;

    pir_pkg::val_t pa_a [0:NPA-1];
    pir_pkg::val_t pa_b [0:NPA-1];
    pir_pkg::val_t pa_p [0:NPA-1];
    pir_pkg::val_t pb_a [0:3];
    pir_pkg::val_t pb_b [0:3];
    pir_pkg::val_t pb_p [0:3];
    pir_pkg::val_t pc_a [0:2];
    pir_pkg::val_t pc_p [0:2];
    pir_pkg::val_t rz;

    logic          out_valid_reg;
    pir_pkg::val_t vx_reg, vy_reg, vz_reg, wx_reg, wy_reg, wz_reg, gdt_reg;
    logic          dz_reg, eos_reg;
    pir_pkg::val_t vx_next, vy_next, vz_next, wx_next, wy_next, gdt_next;
    logic          dz_next;
    line1_t        l1_in, l1_end;
    line2_t        l2_end;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // phase A products, straight from the input word
    assign pa_a[PA_IYX] = pir_pkg::sext(grad_y);  assign pa_b[PA_IYX] = pir_pkg::sext(norm_x);
    assign pa_a[PA_IXY] = pir_pkg::sext(grad_x);  assign pa_b[PA_IXY] = pir_pkg::sext(norm_y);
    assign pa_a[PA_IYZ] = pir_pkg::sext(grad_y);  assign pa_b[PA_IYZ] = pir_pkg::sext(depth);
    assign pa_a[PA_IXZ] = pir_pkg::sext(grad_x);  assign pa_b[PA_IXZ] = pir_pkg::sext(depth);
    assign pa_a[PA_XXI] = pir_pkg::sext(grad_xx); assign pa_b[PA_XXI] = pir_pkg::sext(grad_x);
    assign pa_a[PA_YXI] = pir_pkg::sext(grad_yx); assign pa_b[PA_YXI] = pir_pkg::sext(grad_y);
    assign pa_a[PA_XYI] = pir_pkg::sext(grad_xy); assign pa_b[PA_XYI] = pir_pkg::sext(grad_x);
    assign pa_a[PA_YYI] = pir_pkg::sext(grad_yy); assign pa_b[PA_YYI] = pir_pkg::sext(grad_y);
    assign pa_a[PA_XY]  = pir_pkg::sext(norm_x);  assign pa_b[PA_XY]  = pir_pkg::sext(norm_y);
    assign pa_a[PA_XIX] = pir_pkg::sext(norm_x);  assign pa_b[PA_XIX] = pir_pkg::sext(grad_x);
    assign pa_a[PA_YIY] = pir_pkg::sext(norm_y);  assign pa_b[PA_YIY] = pir_pkg::sext(grad_y);
    assign pa_a[PA_YY]  = pir_pkg::sext(norm_y);  assign pa_b[PA_YY]  = pir_pkg::sext(norm_y);
    assign pa_a[PA_XX]  = pir_pkg::sext(norm_x);  assign pa_b[PA_XX]  = pir_pkg::sext(norm_x);

    // phase B products at stage 5
    assign pb_a[0] = pir_pkg::sext(line1_reg[4].ix); assign pb_b[0] = st5_reg.xy;
    assign pb_a[1] = st5_reg.oyy;                    assign pb_b[1] = pir_pkg::sext(line1_reg[4].iy);
    assign pb_a[2] = st5_reg.oxx;                    assign pb_b[2] = pir_pkg::sext(line1_reg[4].ix);
    assign pb_a[3] = pir_pkg::sext(line1_reg[4].iy); assign pb_b[3] = st5_reg.xy;

    // depth-scaled products once the reciprocal is out
    assign pc_a[0] = pir_pkg::sext(line1_reg[D-1].ix);
    assign pc_a[1] = pir_pkg::sext(line1_reg[D-1].iy);
    assign pc_a[2] = line2_reg[D-6].s;

    genvar g;
    generate
        for (g = 0; g < NPA; g++)
        begin : g_pa
            pir_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
                .clk(clk), .en(en), .a(pa_a[g]), .b(pa_b[g]), .p(pa_p[g])
            );
        end
        for (g = 0; g < 4; g++)
        begin : g_pb
            pir_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
                .clk(clk), .en(en), .a(pb_a[g]), .b(pb_b[g]), .p(pb_p[g])
            );
        end
        for (g = 0; g < 3; g++)
        begin : g_pc
            pir_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
                .clk(clk), .en(en), .a(pc_a[g]), .b(rz), .p(pc_p[g])
            );
        end
    endgenerate

    pir_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .clk(clk), .en(en), .depth(depth), .rz(rz)
    );

    always_comb
    begin
        l1_in.ix   = grad_x;
        l1_in.iy   = grad_y;
        l1_in.zero = (depth == '0);
        l1_in.last = last_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pir_pkg::MODE_PERSP;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L1; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < L1; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line1_reg[0] <= l1_in;
            for (int i = 1; i < L1; i++)
            begin
                line1_reg[i] <= line1_reg[i-1];
            end

            st5_reg.s   <= pir_pkg::sat_add(pa_p[PA_XIX], pa_p[PA_YIY]);
            st5_reg.wxp <= pir_pkg::sat_neg(pa_p[PA_IYZ]);
            st5_reg.wyp <= pa_p[PA_IXZ];
            st5_reg.wz  <= pir_pkg::sat_sub(pa_p[PA_IYX], pa_p[PA_IXY]);
            st5_reg.ga  <= pir_pkg::sat_neg(pir_pkg::sat_add(pa_p[PA_XXI], pa_p[PA_YXI]));
            st5_reg.gb  <= pir_pkg::sat_neg(pir_pkg::sat_add(pa_p[PA_XYI], pa_p[PA_YYI]));
            st5_reg.oyy <= pir_pkg::sat_add(ONE, pa_p[PA_YY]);
            st5_reg.oxx <= pir_pkg::sat_add(ONE, pa_p[PA_XX]);
            st5_reg.xy  <= pa_p[PA_XY];

            line2_reg[0].s   <= st5_reg.s;
            line2_reg[0].wxp <= st5_reg.wxp;
            line2_reg[0].wyp <= st5_reg.wyp;
            line2_reg[0].wz  <= st5_reg.wz;
            line2_reg[0].gdt <= pir_pkg::sat_add(st5_reg.ga, st5_reg.gb);
            line2_reg[0].wx  <= '0;
            line2_reg[0].wy  <= '0;
            for (int i = 1; i < L2; i++)
            begin
                if (i != WXI)
                begin
                    line2_reg[i] <= line2_reg[i-1];
                end
            end
            // wx / wy join the line when phase B products land
            line2_reg[WXI].s   <= line2_reg[WXI-1].s;
            line2_reg[WXI].wxp <= line2_reg[WXI-1].wxp;
            line2_reg[WXI].wyp <= line2_reg[WXI-1].wyp;
            line2_reg[WXI].wz  <= line2_reg[WXI-1].wz;
            line2_reg[WXI].gdt <= line2_reg[WXI-1].gdt;
            line2_reg[WXI].wx  <= pir_pkg::sat_sub(pir_pkg::sat_neg(pb_p[0]), pb_p[1]);
            line2_reg[WXI].wy  <= pir_pkg::sat_add(pb_p[2], pb_p[3]);
        end
    end

    assign l1_end = line1_reg[L1-1];
    assign l2_end = line2_reg[L2-1];

    always_comb
    begin
        if (pir_pkg::is_parallel(mode_reg))
        begin
            vx_next  = pir_pkg::sext(l1_end.ix);
            vy_next  = pir_pkg::sext(l1_end.iy);
            vz_next  = '0;
            wx_next  = l2_end.wxp;
            wy_next  = l2_end.wyp;
            gdt_next = (mode_reg == pir_pkg::MODE_PAR_DEPTH) ? l2_end.gdt : '0;
            dz_next  = 1'b0;
        end
        else
        begin
            vx_next  = pc_p[0];
            vy_next  = pc_p[1];
            vz_next  = pir_pkg::sat_neg(pc_p[2]);
            wx_next  = l2_end.wx;
            wy_next  = l2_end.wy;
            gdt_next = '0;
            dz_next  = l1_end.zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[L1-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            vz_reg  <= vz_next;
            wx_reg  <= wx_next;
            wy_reg  <= wy_next;
            wz_reg  <= l2_end.wz;
            gdt_reg <= gdt_next;
            dz_reg  <= dz_next;
            eos_reg <= l1_end.last;
        end
    end

    assign out_valid           = out_valid_reg;
    assign row_vx              = vx_reg;
    assign row_vy              = vy_reg;
    assign row_vz              = vz_reg;
    assign row_wx              = wx_reg;
    assign row_wy              = wy_reg;
    assign row_wz              = wz_reg;
    assign gradient_depth_term = gdt_reg;
    assign depth_zero          = dz_reg;
    assign end_of_set          = eos_reg;

endmodule

// File: rtl/pir_mul.sv
// Four-stage fixed-point multiplier: magnitude, 24x24 partials, sum, round and saturate.
// Depends on pir_pkg.
module pir_mul #(
    parameter int FRAC_BITS = pir_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           en,
    input  pir_pkg::val_t  a,
    input  pir_pkg::val_t  b,
    output pir_pkg::val_t  p
);
    localparam int VW = pir_pkg::VW;
    localparam int HW = VW / 2;
    localparam int PW = 2 * VW;

    logic [VW-1:0] ma_reg, mb_reg;
    logic          neg1_reg, neg2_reg, neg3_reg;
    logic [VW-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [PW-1:0] sum_reg;
    pir_pkg::val_t p_reg;

    logic [VW-1:0] a_u, b_u;
    logic [PW-1:0] rnd, shr;
    pir_pkg::val_t p_next;

    assign a_u = a;
    assign b_u = b;

    always_comb
    begin
        rnd = sum_reg + (PW'(1) << (FRAC_BITS - 1));
        shr = rnd >> FRAC_BITS;
        if (shr[PW-1:VW-1] != '0)
        begin
            p_next = neg3_reg ? pir_pkg::VAL_MIN : pir_pkg::VAL_MAX;
        end
        else if (neg3_reg)
        begin
            p_next = {VW{1'b0}} - shr[VW-1:0];
        end
        else
        begin
            p_next = shr[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[VW-1] ^ b[VW-1];
            ma_reg   <= a[VW-1] ? ({VW{1'b0}} - a_u) : a_u;
            mb_reg   <= b[VW-1] ? ({VW{1'b0}} - b_u) : b_u;
            neg2_reg <= neg1_reg;
            pp00_reg <= ma_reg[HW-1:0]  * mb_reg[HW-1:0];
            pp01_reg <= ma_reg[HW-1:0]  * mb_reg[VW-1:HW];
            pp10_reg <= ma_reg[VW-1:HW] * mb_reg[HW-1:0];
            pp11_reg <= ma_reg[VW-1:HW] * mb_reg[VW-1:HW];
            neg3_reg <= neg2_reg;
            sum_reg  <= PW'(pp00_reg) + (PW'(pp01_reg) << HW) + (PW'(pp10_reg) << HW)
                        + (PW'(pp11_reg) << VW);
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/pir_recip.sv
// Pipelined reciprocal of depth: one quotient bit per stage, restoring division.
// Depends on pir_pkg.
module pir_recip #(
    parameter int FRAC_BITS = pir_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           en,
    input  pir_pkg::in_t   depth,
    output pir_pkg::val_t  rz
);
    localparam int NW = pir_pkg::div_width(FRAC_BITS);
    localparam int IW = pir_pkg::IW;
    localparam int VW = pir_pkg::VW;

    logic [IW-1:0] dv_m_reg   [0:NW];
    logic [IW-1:0] dv_rem_reg [0:NW];
    logic [NW-1:0] dv_num_reg [0:NW];
    logic [NW-1:0] dv_q_reg   [0:NW];
    logic          dv_neg_reg [0:NW];
    logic          dv_zero_reg[0:NW];
    pir_pkg::val_t rz_reg;

    logic [IW-1:0] d_u, dm;
    logic [63:0]   qq;
    pir_pkg::val_t rz_next;

    assign d_u = depth;
    assign dm  = depth[IW-1] ? ({IW{1'b0}} - d_u) : d_u;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_m_reg[0]    <= dm;
            dv_rem_reg[0]  <= '0;
            dv_num_reg[0]  <= (NW'(1) << (2 * FRAC_BITS)) + NW'(dm >> 1);
            dv_q_reg[0]    <= '0;
            dv_neg_reg[0]  <= depth[IW-1];
            dv_zero_reg[0] <= (depth == '0);
        end
    end

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_div
            logic [IW:0] trial;
            logic        ge;
            assign trial = {dv_rem_reg[k], dv_num_reg[k][NW-1]};
            assign ge    = (trial >= {1'b0, dv_m_reg[k]});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_m_reg[k+1]    <= dv_m_reg[k];
                    dv_rem_reg[k+1]  <= ge ? IW'(trial - {1'b0, dv_m_reg[k]}) : trial[IW-1:0];
                    dv_num_reg[k+1]  <= dv_num_reg[k] << 1;
                    dv_q_reg[k+1]    <= {dv_q_reg[k][NW-2:0], ge};
                    dv_neg_reg[k+1]  <= dv_neg_reg[k];
                    dv_zero_reg[k+1] <= dv_zero_reg[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        qq = 64'(dv_q_reg[NW]);
        if (dv_zero_reg[NW])
        begin
            rz_next = pir_pkg::VAL_MAX;
        end
        else if (qq > 64'(pir_pkg::VAL_MAX))
        begin
            rz_next = dv_neg_reg[NW] ? pir_pkg::VAL_MIN : pir_pkg::VAL_MAX;
        end
        else if (dv_neg_reg[NW])
        begin
            rz_next = {VW{1'b0}} - qq[VW-1:0];
        end
        else
        begin
            rz_next = qq[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rz_reg <= rz_next;
        end
    end

    assign rz = rz_reg;

endmodule

// File: rtl/pir_chk.sv
// Port-level checker for photometric_interaction_row_core, attached by bind.
// Depends on the top level's port list only.
module pir_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [47:0] row_vz,
    input logic signed [47:0] row_wz,
    input logic signed [47:0] gradient_depth_term,
    input logic               depth_zero
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(row_wz))
        else $error("out word changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked output");

    a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_zero |-> gradient_depth_term == '0)
        else $error("depth flag with a depth term");

    a_term_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gradient_depth_term != '0 |-> row_vz == '0 && !depth_zero)
        else $error("depth term outside parallel mode");

endmodule

bind photometric_interaction_row_core pir_chk u_pir_chk (.*);

// File: bench/tb.sv
// Self-checking bench for photometric_interaction_row_core: drives random and corner pixels,
// predicts each interaction row in fixed point and compares the whole row at once.
// Depends on pir_pkg and the RTL of the row core.
module tb;

    localparam int F = pir_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 41;

    typedef struct packed {
        pir_pkg::val_t vx, vy, vz, wx, wy, wz, gterm;
        logic dz, eos;
    } row_t;

    typedef struct {
        pir_pkg::in_t ix, iy, x, y, z, ixx, ixy, iyx, iyy;
        logic last;
    } pixel_t;

    // exact product rounded half away from zero, saturated to 48 bits
    function automatic pir_pkg::val_t qmul(pir_pkg::val_t a, pir_pkg::val_t b);
        logic signed [97:0] p;
        logic [97:0] m;
        logic neg;
        p = 98'(a) * 98'(b);
        neg = p[97];
        m = neg ? -p : p;
        m = (m + (98'd1 << (F - 1))) >> F;
        if (neg)
            return (m >= (98'd1 << 47)) ? pir_pkg::VAL_MIN : pir_pkg::val_t'(-m);
        return (m > 98'(pir_pkg::VAL_MAX)) ? pir_pkg::VAL_MAX : pir_pkg::val_t'(m);
    endfunction

    function automatic pir_pkg::val_t qrecip(pir_pkg::in_t z);
        logic [63:0] m, q;
        m = z[31] ? 64'(-longint'(z)) : 64'(z);
        q = ((64'd1 << (2 * F)) + m / 2) / m;
        if (z[31])
            return (q >= (64'd1 << 47)) ? pir_pkg::VAL_MIN : pir_pkg::val_t'(-q);
        return (q > 64'(pir_pkg::VAL_MAX)) ? pir_pkg::VAL_MAX : pir_pkg::val_t'(q);
    endfunction

    function automatic row_t predict_row(pixel_t p, pir_pkg::mode_t mode);
        row_t r;
        pir_pkg::val_t ix, iy, x, y, z, rz, xy, one, a, b;
        ix = pir_pkg::sext(p.ix); iy = pir_pkg::sext(p.iy);
        x = pir_pkg::sext(p.x); y = pir_pkg::sext(p.y); z = pir_pkg::sext(p.z);
        one = pir_pkg::val_t'(1) <<< F;
        r.wz = pir_pkg::sat_sub(qmul(iy, x), qmul(ix, y));
        r.gterm = '0;
        r.dz = 1'b0;
        r.eos = p.last;
        if (mode == pir_pkg::MODE_PAR || mode == pir_pkg::MODE_PAR_DEPTH)
        begin
            r.vx = ix; r.vy = iy; r.vz = '0;
            r.wx = pir_pkg::sat_neg(qmul(iy, z));
            r.wy = qmul(ix, z);
            if (mode == pir_pkg::MODE_PAR_DEPTH)
            begin
                a = pir_pkg::sat_neg(pir_pkg::sat_add(qmul(pir_pkg::sext(p.ixx), ix),
                                                      qmul(pir_pkg::sext(p.iyx), iy)));
                b = pir_pkg::sat_neg(pir_pkg::sat_add(qmul(pir_pkg::sext(p.ixy), ix),
                                                      qmul(pir_pkg::sext(p.iyy), iy)));
                r.gterm = pir_pkg::sat_add(a, b);
            end
        end
        else
        begin
            if (p.z == 0)
            begin
                r.dz = 1'b1;
                rz = pir_pkg::VAL_MAX;
            end
            else
                rz = qrecip(p.z);
            xy = qmul(x, y);
            r.vx = qmul(ix, rz);
            r.vy = qmul(iy, rz);
            r.vz = pir_pkg::sat_neg(qmul(pir_pkg::sat_add(qmul(x, ix), qmul(y, iy)), rz));
            r.wx = pir_pkg::sat_sub(pir_pkg::sat_neg(qmul(ix, xy)),
                                    qmul(pir_pkg::sat_add(one, qmul(y, y)), iy));
            r.wy = pir_pkg::sat_add(qmul(pir_pkg::sat_add(one, qmul(x, x)), ix),
                                    qmul(iy, xy));
        end
        return r;
    endfunction

    class row_scoreboard;
        row_t pending[$];
        int errors = 0;

        function void note_pixel(pixel_t p, pir_pkg::mode_t mode);
            pending.push_back(predict_row(p, mode));
        endfunction

        function void check_row(row_t got);
            row_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("row with no pixel pending");
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                errors++;
                if (errors <= 10)
                    $display({"row mismatch: exp %h %h %h %h %h %h %h %b %b",
                              " got %h %h %h %h %h %h %h %b %b"},
                        e.vx, e.vy, e.vz, e.wx, e.wy, e.wz, e.gterm, e.dz, e.eos,
                        got.vx, got.vy, got.vz, got.wx, got.wy, got.wz, got.gterm,
                        got.dz, got.eos);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
    pir_pkg::in_t grad_x, grad_y, norm_x, norm_y, depth, grad_xx, grad_xy, grad_yx, grad_yy;
    logic last_pixel;
    pir_pkg::val_t row_vx, row_vy, row_vz, row_wx, row_wy, row_wz, gradient_depth_term;
    logic depth_zero, end_of_set;
    logic [1:0] cfg_data;

    row_scoreboard rows = new();
    pir_pkg::mode_t cur_mode;
    int hold_off = 0;

    photometric_interaction_row_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .grad_x(grad_x), .grad_y(grad_y), .norm_x(norm_x), .norm_y(norm_y),
        .depth(depth), .grad_xx(grad_xx), .grad_xy(grad_xy), .grad_yx(grad_yx),
        .grad_yy(grad_yy), .last_pixel(last_pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_vx(row_vx), .row_vy(row_vy), .row_vz(row_vz), .row_wx(row_wx),
        .row_wy(row_wy), .row_wz(row_wz), .gradient_depth_term(gradient_depth_term),
        .depth_zero(depth_zero), .end_of_set(end_of_set),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        row_t got;
        int w;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (hold_off > 0)
            begin
                w = hold_off;
                hold_off = 0;
            end
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.vx = row_vx; got.vy = row_vy; got.vz = row_vz;
            got.wx = row_wx; got.wy = row_wy; got.wz = row_wz;
            got.gterm = gradient_depth_term; got.dz = depth_zero; got.eos = end_of_set;
            rows.check_row(got);
        end
    end

    task automatic write_mode(pir_pkg::mode_t m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    task automatic send_pixel(pixel_t p, bit no_gap);
        int g;
        g = no_gap ? 0 : $urandom_range(0, 10);
        if (!no_gap && $urandom_range(0, 2) == 0) g = 0;
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        grad_x <= p.ix; grad_y <= p.iy; norm_x <= p.x; norm_y <= p.y; depth <= p.z;
        grad_xx <= p.ixx; grad_xy <= p.ixy; grad_yx <= p.iyx; grad_yy <= p.iyy;
        last_pixel <= p.last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        rows.note_pixel(p, cur_mode);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (rows.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic pir_pkg::in_t pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return pir_pkg::in_t'($urandom_range(0, 3)) <<< 16;
            4: return -(pir_pkg::in_t'($urandom_range(0, 3)) <<< 16);
            5: return pir_pkg::in_t'($signed($urandom_range(0, 32'h0003ffff))) - 32'sh20000;
            default: return pir_pkg::in_t'($urandom);
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.ix = pick_value(); p.iy = pick_value(); p.x = pick_value(); p.y = pick_value();
        p.z = pick_value();
        if ($urandom_range(0, 9) == 0) p.z = pir_pkg::in_t'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) p.z = -pir_pkg::in_t'($urandom_range(1, 3));
        p.ixx = pick_value(); p.ixy = pick_value(); p.iyx = pick_value(); p.iyy = pick_value();
        p.last = $urandom_range(0, 15) == 0;
        return p;
    endfunction

    function automatic pixel_t fill_pixel(pir_pkg::in_t v, logic last);
        pixel_t p;
        p.ix = v; p.iy = v; p.x = v; p.y = v; p.z = v;
        p.ixx = v; p.ixy = v; p.iyx = v; p.iyy = v; p.last = last;
        return p;
    endfunction

    initial
    begin
        pixel_t p;
        pir_pkg::mode_t modes[5] = '{pir_pkg::MODE_PERSP, pir_pkg::MODE_PAR,
                                     pir_pkg::MODE_PAR_DEPTH, pir_pkg::mode_t'(3),
                                     pir_pkg::MODE_PERSP};
        rst_n = 0;
        in_valid = 0; cfg_valid = 0; cfg_data = '0; last_pixel = 0;
        grad_x = 0; grad_y = 0; norm_x = 0; norm_y = 0; depth = 0;
        grad_xx = 0; grad_xy = 0; grad_yx = 0; grad_yy = 0;
        cur_mode = pir_pkg::MODE_PERSP;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // corners in each mode: zero depth, tiny depth, extremes
        foreach (modes[m])
        begin
            write_mode(modes[m]);
            send_pixel(fill_pixel(32'sh7fffffff, 1'b0), 0);
            send_pixel(fill_pixel(32'sh80000000, 1'b1), 0);
            send_pixel(fill_pixel(0, 1'b0), 0);
            p = fill_pixel(32'sh10000, 1'b0); p.z = 0; p.iy = 0;
            send_pixel(p, 0);
            p = fill_pixel(-32'sh30000, 1'b1); p.z = 1;
            send_pixel(p, 0);
            drain();
        end

        // random phases across all modes; one phase saturates the pipeline
        for (int ph = 0; ph < 8; ph++)
        begin
            write_mode(pir_pkg::mode_t'(ph % 4));
            if (ph == 2) hold_off = 300;
            for (int i = 0; i < 240; i++)
                send_pixel(rand_pixel(), ph == 2);
            drain();
        end

        if (rows.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
